[rtl/enms_pkg.sv]
// Shared types and constants for the edge non-maximum suppression unit.
`timescale 1ns / 1ps
`default_nettype none

package enms_pkg;

    localparam int unsigned CFG_W    = 11;
    localparam int unsigned MAG_W    = 16;
    localparam int unsigned GRAD_W   = 16;
    localparam int unsigned MIN_SIZE = 3;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic signed [GRAD_W-1:0] t_grad;

    typedef struct packed {
        logic signed [GRAD_W-1:0] minor;
        logic signed [GRAD_W+1:0] diag;
        logic [GRAD_W:0]          major_abs;
        logic [MAG_W-1:0]         centre;
        logic [MAG_W-1:0]         m1;
        logic [MAG_W-1:0]         m2;
        logic [MAG_W-1:0]         m3;
        logic [MAG_W-1:0]         m4;
        logic                     strict1;
        logic                     strict2;
    } t_nms_ops;

endpackage

`default_nettype wire

[rtl/enms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module enms_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/enms_datapath.sv]
// Suppression arithmetic: products, interpolated sums, magnitudes and compare.
`timescale 1ns / 1ps
`default_nettype none

module enms_datapath #(
    parameter int unsigned TAG_W = 37
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [TAG_W-1:0]  i_tag,
    input  wire enms_pkg::t_nms_ops i_ops,
    output logic                   o_valid,
    output logic [TAG_W-1:0]       o_tag,
    output logic                   o_keep
);

    import enms_pkg::*;

    localparam int unsigned PA_W  = 2 * GRAD_W + 1;
    localparam int unsigned PD_W  = 2 * GRAD_W + 3;
    localparam int unsigned PG_W  = GRAD_W + 1 + MAG_W;
    localparam int unsigned SUM_W = PD_W + 1;

    logic signed [MAG_W:0] w_m1;
    logic signed [MAG_W:0] w_m2;
    logic signed [MAG_W:0] w_m3;
    logic signed [MAG_W:0] w_m4;

    logic signed [PA_W-1:0] n_pa1, n_pa3;
    logic signed [PD_W-1:0] n_pd2, n_pd4;
    logic [PG_W-1:0]        n_pg;

    logic                   r_p_valid, r_s_valid, r_a_valid;
    logic [TAG_W-1:0]       r_p_tag, r_s_tag, r_a_tag;
    logic                   r_p_strict1, r_p_strict2;
    logic                   r_s_strict1, r_s_strict2;
    logic                   r_a_strict1, r_a_strict2;
    logic signed [PA_W-1:0] r_pa1, r_pa3;
    logic signed [PD_W-1:0] r_pd2, r_pd4;
    logic [PG_W-1:0]        r_pg, r_sg, r_ag;
    logic signed [SUM_W-1:0] r_sum1, r_sum2;
    logic [SUM_W-1:0]       r_abs1, r_abs2;
    logic [SUM_W-1:0]       n_abs1, n_abs2;
    logic                   w_sup1, w_sup2;

    assign w_m1 = $signed({1'b0, i_ops.m1});
    assign w_m2 = $signed({1'b0, i_ops.m2});
    assign w_m3 = $signed({1'b0, i_ops.m3});
    assign w_m4 = $signed({1'b0, i_ops.m4});

    assign n_pa1 = $signed(i_ops.minor) * w_m1;
    assign n_pd2 = $signed(i_ops.diag) * w_m2;
    assign n_pa3 = $signed(i_ops.minor) * w_m3;
    assign n_pd4 = $signed(i_ops.diag) * w_m4;
    assign n_pg  = i_ops.major_abs * i_ops.centre;

    assign n_abs1 = r_sum1[SUM_W-1] ? SUM_W'(-r_sum1) : SUM_W'(r_sum1);
    assign n_abs2 = r_sum2[SUM_W-1] ? SUM_W'(-r_sum2) : SUM_W'(r_sum2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
            r_s_valid <= r_p_valid;
            r_a_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_tag     <= i_tag;
            r_p_strict1 <= i_ops.strict1;
            r_p_strict2 <= i_ops.strict2;
            r_pa1       <= n_pa1;
            r_pd2       <= n_pd2;
            r_pa3       <= n_pa3;
            r_pd4       <= n_pd4;
            r_pg        <= n_pg;

            r_s_tag     <= r_p_tag;
            r_s_strict1 <= r_p_strict1;
            r_s_strict2 <= r_p_strict2;
            r_sum1      <= SUM_W'(r_pa1) + SUM_W'(r_pd2);
            r_sum2      <= SUM_W'(r_pa3) + SUM_W'(r_pd4);
            r_sg        <= r_pg;

            r_a_tag     <= r_s_tag;
            r_a_strict1 <= r_s_strict1;
            r_a_strict2 <= r_s_strict2;
            r_abs1      <= n_abs1;
            r_abs2      <= n_abs2;
            r_ag        <= r_sg;
        end
    end

    assign w_sup1 = r_a_strict1 ? (SUM_W'(r_ag) < r_abs1) : (SUM_W'(r_ag) <= r_abs1);
    assign w_sup2 = r_a_strict2 ? (SUM_W'(r_ag) < r_abs2) : (SUM_W'(r_ag) <= r_abs2);

    assign o_valid = r_a_valid;
    assign o_tag   = r_a_tag;
    assign o_keep  = !w_sup1 && !w_sup2;

endmodule

`default_nettype wire

[rtl/edge_non_maximum_suppression_unit.sv]
// Top level of the edge non-maximum suppression unit.
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel per clock in raster order and gives one request for every interior
// centre pixel after the pixel that completes its 3x3 neighbourhood is accepted; border
// pixels give none. Two magnitude line RAMs (one per row parity, written on its rows)
// and one gradient line RAM written every pixel, all read every pixel, hold the
// previous rows; the whole pipeline holds while a finished request is stalled at the
// output. The user must write image width and height over the APB port while the unit
// is idle (unenforced); they are clamped to three up to MAX_WIDTH and MAX_HEIGHT.
module edge_non_maximum_suppression_unit #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire enms_pkg::t_mag                i_magnitude,
    input  wire enms_pkg::t_grad               i_grad_x,
    input  wire enms_pkg::t_grad               i_grad_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]       o_out_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]      o_out_row,
    output enms_pkg::t_mag                     o_kept_value,
    output logic                               o_frame_last
);

    import enms_pkg::*;

    localparam int unsigned CW    = $clog2(MAX_WIDTH);
    localparam int unsigned RW    = $clog2(MAX_HEIGHT);
    localparam int unsigned WW    = CW + 1;
    localparam int unsigned HW    = RW + 1;
    localparam int unsigned TAG_W = CW + RW + 1 + MAG_W;

    logic [CFG_W-1:0] r_cfg_width, r_cfg_height;
    logic [WW-1:0]    w_width;
    logic [HW-1:0]    w_height;

    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [WW-1:0]    w_col_cur, w_col_inc;
    logic [HW-1:0]    w_row_cur, w_row_inc;
    logic [CW-1:0]    w_c;
    logic             w_emit, w_last;
    logic             w_en, w_accept;

    t_mag             w_mag_rd0, w_mag_rd1;
    logic [2*GRAD_W-1:0] w_grad_rd;

    logic             r_s1_valid, r_s1_emit, r_s1_last, r_s1_bank;
    t_mag             r_s1_mag;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;

    t_mag             r_win [9];
    t_mag             n_win [9];
    logic [2*GRAD_W-1:0] r_gd;

    t_grad            w_ux, w_uy;
    logic [GRAD_W:0]  w_abs_x, w_abs_y;
    logic             w_same, w_ymaj;
    t_grad            w_major;
    t_nms_ops         n_ops;

    logic             r_s2_valid;
    t_nms_ops         r_s2_ops;
    logic [TAG_W-1:0] r_s2_tag;

    logic             w_dp_valid, w_dp_keep;
    logic [TAG_W-1:0] w_dp_tag;
    t_mag             w_dp_mag;

    logic             r_out_valid;
    logic [CW-1:0]    r_out_col;
    logic [RW-1:0]    r_out_row;
    t_mag             r_out_kept;
    logic             r_out_last;

    // Configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  r_cfg_width  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(r_cfg_width);
            REG_IMAGE_HEIGHT: prdata = 32'(r_cfg_height);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_cfg_width < CFG_W'(MIN_SIZE)) begin
            w_width = WW'(MIN_SIZE);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_cfg_width);
        end
        if (r_cfg_height < CFG_W'(MIN_SIZE)) begin
            w_height = HW'(MIN_SIZE);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            w_height = HW'(MAX_HEIGHT);
        end else begin
            w_height = HW'(r_cfg_height);
        end
    end

    // Handshake
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;

    // Pixel position
    always_comb begin
        w_col_cur = {1'b0, r_col};
        w_row_cur = {1'b0, r_row};
        if (w_col_cur >= w_width) begin
            w_col_cur = '0;
            w_row_cur = w_row_cur + 1'b1;
        end
        if (w_row_cur >= w_height) begin
            w_row_cur = '0;
        end
        w_col_inc = w_col_cur + 1'b1;
        w_row_inc = w_row_cur;
        if (w_col_inc >= w_width) begin
            w_col_inc = '0;
            w_row_inc = w_row_cur + 1'b1;
            if (w_row_inc >= w_height) begin
                w_row_inc = '0;
            end
        end
    end

    assign w_c    = w_col_cur[CW-1:0];
    assign n_col  = w_col_inc[CW-1:0];
    assign n_row  = w_row_inc[RW-1:0];
    assign w_emit = (w_col_cur >= WW'(2)) && (w_row_cur >= HW'(2));
    assign w_last = (w_col_cur == w_width - 1'b1) && (w_row_cur == w_height - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line stores
    enms_ram #(.WIDTH(MAG_W), .DEPTH(MAX_WIDTH)) u_mag_line0 (
        .i_clk   (i_clk),
        .i_we    (w_accept && !w_row_cur[0]),
        .i_waddr (w_c),
        .i_wdata (i_magnitude),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_mag_rd0)
    );

    enms_ram #(.WIDTH(MAG_W), .DEPTH(MAX_WIDTH)) u_mag_line1 (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_row_cur[0]),
        .i_waddr (w_c),
        .i_wdata (i_magnitude),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_mag_rd1)
    );

    enms_ram #(.WIDTH(2 * GRAD_W), .DEPTH(MAX_WIDTH)) u_grad_line (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (w_c),
        .i_wdata ({i_grad_y, i_grad_x}),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_grad_rd)
    );

    // Stage 1: line-store read returns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_emit <= w_emit;
            r_s1_last <= w_last;
            r_s1_bank <= w_row_cur[0];
            r_s1_mag  <= i_magnitude;
            r_s1_col  <= w_c - 1'b1;
            r_s1_row  <= w_row_cur[RW-1:0] - 1'b1;
        end
    end

    // Window shift
    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_s1_bank ? w_mag_rd1 : w_mag_rd0;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_s1_bank ? w_mag_rd0 : w_mag_rd1;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
            r_gd <= '0;
        end else if (w_en && r_s1_valid) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= n_win[i];
            end
            r_gd <= w_grad_rd;
        end
    end

    // Branch selection on the centre gradient
    assign w_ux    = r_gd[GRAD_W-1:0];
    assign w_uy    = r_gd[2*GRAD_W-1:GRAD_W];
    assign w_abs_x = w_ux[GRAD_W-1] ? (GRAD_W+1)'(-(GRAD_W+1)'(w_ux)) : (GRAD_W+1)'(w_ux);
    assign w_abs_y = w_uy[GRAD_W-1] ? (GRAD_W+1)'(-(GRAD_W+1)'(w_uy)) : (GRAD_W+1)'(w_uy);
    assign w_same  = (w_ux != '0) && (w_uy != '0) && (w_ux[GRAD_W-1] == w_uy[GRAD_W-1]);
    assign w_ymaj  = w_abs_x < w_abs_y;
    assign w_major = w_ymaj ? w_uy : w_ux;

    always_comb begin
        n_ops.minor     = w_ymaj ? w_ux : w_uy;
        n_ops.major_abs = w_ymaj ? w_abs_y : w_abs_x;
        if (w_same) begin
            n_ops.diag = (GRAD_W+2)'(w_major) - (GRAD_W+2)'(n_ops.minor);
        end else begin
            n_ops.diag = -((GRAD_W+2)'(w_major) + (GRAD_W+2)'(n_ops.minor));
        end
        n_ops.centre  = n_win[4];
        n_ops.m1      = w_same ? n_win[8] : n_win[2];
        n_ops.m2      = w_ymaj ? (w_same ? n_win[7] : n_win[1]) : n_win[5];
        n_ops.m3      = w_same ? n_win[0] : n_win[6];
        n_ops.m4      = w_ymaj ? (w_same ? n_win[1] : n_win[7]) : n_win[3];
        n_ops.strict1 = !w_same && w_ymaj;
        n_ops.strict2 = !w_same && !w_ymaj;
    end

    // Stage 2: operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_ops <= n_ops;
            r_s2_tag <= {r_s1_col, r_s1_row, r_s1_last, n_win[4]};
        end
    end

    enms_datapath #(.TAG_W(TAG_W)) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_valid),
        .i_tag   (r_s2_tag),
        .i_ops   (r_s2_ops),
        .o_valid (w_dp_valid),
        .o_tag   (w_dp_tag),
        .o_keep  (w_dp_keep)
    );

    assign w_dp_mag = w_dp_tag[MAG_W-1:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_col  <= w_dp_tag[TAG_W-1 -: CW];
            r_out_row  <= w_dp_tag[MAG_W+1 +: RW];
            r_out_last <= w_dp_tag[MAG_W];
            r_out_kept <= w_dp_keep ? w_dp_mag : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_kept_value = r_out_kept;
    assign o_frame_last = r_out_last;

`ifndef NO_ASSERTIONS
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_s1_valid)
        else $error("accepted pixel did not enter stage 1");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> ($stable(r_gd) && $stable(r_col) && $stable(r_row)))
        else $error("line state moved while stalled");

    a_out_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_col != '0) && (o_out_row != '0)))
        else $error("request for a border pixel");
`endif

endmodule

`default_nettype wire

[test/tb_edge_non_maximum_suppression_unit.sv]
// Self-checking testbench: streams pixels through the suppression unit and checks every field of each result.
`timescale 1ns / 1ps

module tb_edge_non_maximum_suppression_unit;
    import enms_pkg::*;

    localparam int unsigned MAX_W  = 1024;
    localparam int unsigned MAX_H  = 1024;
    localparam int unsigned FILL_W = 64;

    localparam t_grad DIR_GX [7] = '{16'sd5, 16'sd100, 16'sh8000, 16'sd7, 16'sh7FFF,
                                     16'sd0, -16'sd3};
    localparam t_grad DIR_GY [7] = '{-16'sd9, 16'sh7FFF, -16'sd5, 16'sh8000, -16'sd1,
                                     16'sd0, 16'sd2};

    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
        t_mag       kept;
        logic       last;
    } t_nms_result;

    class suppression_checker;
        t_nms_result   expected_maxima [$];
        t_mag          mag_lines [2*MAX_W];
        logic [31:0]   grad_line [MAX_W];
        t_mag          window [9];
        logic [31:0]   grad_delay;
        int unsigned   col_pos;
        int unsigned   row_pos;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        int unsigned   errors;

        function new();
            foreach (mag_lines[i]) mag_lines[i] = '0;
            foreach (grad_line[i]) grad_line[i] = '0;
            foreach (window[i]) window[i] = '0;
            grad_delay = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
        endfunction

        function void set_size(logic sel, logic [CFG_W-1:0] value);
            if (sel == REG_IMAGE_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned maxv);
            if (v < MIN_SIZE) return MIN_SIZE;
            if (v > maxv) return maxv;
            return v;
        endfunction

        function longint absl(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function bit centre_survives(logic [31:0] cg);
            longint ux, uy, g0, nw, n, ne, w, c, e, sw, s, se;
            bit same_sign, y_major;
            ux = $signed(cg[15:0]);
            uy = $signed(cg[31:16]);
            nw = window[0]; n = window[1]; ne = window[2];
            w  = window[3]; c = window[4]; e  = window[5];
            sw = window[6]; s = window[7]; se = window[8];
            same_sign = (ux > 0 && uy > 0) || (ux < 0 && uy < 0);
            y_major   = absl(ux) < absl(uy);
            if (same_sign && y_major) begin
                g0 = absl(uy * c);
                return !(g0 <= absl(ux * se + (uy - ux) * s) ||
                         g0 <= absl(ux * nw + (uy - ux) * n));
            end else if (same_sign) begin
                g0 = absl(ux * c);
                return !(g0 <= absl(uy * se + (ux - uy) * e) ||
                         g0 <= absl(uy * nw + (ux - uy) * w));
            end else if (y_major) begin
                g0 = absl(uy * c);
                return !(g0 < absl(ux * ne - (uy + ux) * n) ||
                         g0 <= absl(ux * sw - (uy + ux) * s));
            end
            g0 = absl(ux * c);
            return !(g0 <= absl(uy * ne - (ux + uy) * e) ||
                     g0 < absl(uy * sw - (ux + uy) * w));
        endfunction

        function void take_pixel(t_mag mag, t_grad gx, t_grad gy);
            int unsigned w, h, c, r, cur, up, k;
            t_mag north, mid;
            logic [31:0] centre;
            t_nms_result res;
            w = clamp_size(width_reg, MAX_W);
            h = clamp_size(height_reg, MAX_H);
            c = col_pos;
            r = row_pos;
            if (c >= w) begin
                c = 0;
                r++;
            end
            if (r >= h) r = 0;
            cur   = (r & 1) * MAX_W + c;
            up    = ((r & 1) ^ 1) * MAX_W + c;
            north = mag_lines[cur];
            mid   = mag_lines[up];
            mag_lines[cur] = mag;
            for (k = 0; k < 3; k++) begin
                window[k*3]   = window[k*3+1];
                window[k*3+1] = window[k*3+2];
            end
            window[2] = north;
            window[5] = mid;
            window[8] = mag;
            centre     = grad_delay;
            grad_delay = grad_line[c];
            grad_line[c] = {gy, gx};
            if (r >= 2 && c >= 2) begin
                res.col  = 10'(c - 1);
                res.row  = 10'(r - 1);
                res.kept = centre_survives(centre) ? window[4] : '0;
                res.last = (c == w - 1) && (r == h - 1);
                expected_maxima = {expected_maxima, res};
            end
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void report(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            if (errors <= 100)
                $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(logic [9:0] col, logic [9:0] row, t_mag kept, logic last);
            t_nms_result want;
            if (expected_maxima.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t unexpected result: expected none, actual col %0d row %0d",
                             $time, col, row);
                return;
            end
            want = expected_maxima.pop_front();
            if (col !== want.col) report("out_col", 16'(want.col), 16'(col));
            if (row !== want.row) report("out_row", 16'(want.row), 16'(row));
            if (kept !== want.kept) report("kept_value", want.kept, kept);
            if (last !== want.last) report("frame_last", 16'(want.last), 16'(last));
        endfunction

        function int unsigned pending_count();
            return expected_maxima.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_mag        i_magnitude = '0;
    t_grad       i_grad_x = '0;
    t_grad       i_grad_y = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [9:0]  o_out_col;
    logic [9:0]  o_out_row;
    t_mag        o_kept_value;
    logic        o_frame_last;

    bit gaps_on = 1'b1;
    suppression_checker sb;

    edge_non_maximum_suppression_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_magnitude  (i_magnitude),
        .i_grad_x     (i_grad_x),
        .i_grad_y     (i_grad_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_kept_value (o_kept_value),
        .o_frame_last (o_frame_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 29);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && sb != null) begin
            if (i_in_valid && !o_in_stall)
                sb.take_pixel(i_magnitude, i_grad_x, i_grad_y);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_col, o_out_row, o_kept_value, o_frame_last);
        end
    end

    function automatic t_grad rand_grad();
        logic [15:0] v;
        case ($urandom_range(0, 4))
            0: v = 16'($urandom_range(0, 8) - 4);
            1: begin
                case ($urandom_range(0, 3))
                    0: v = 16'h8000;
                    1: v = 16'h7FFF;
                    2: v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            2: v = 16'($urandom_range(0, 600) - 300);
            default: v = 16'($urandom);
        endcase
        return t_grad'(v);
    endfunction

    function automatic t_mag rand_mag();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return CFG_W'($urandom_range(0, 2));
            1: return CFG_W'($urandom_range(1025, 2047));
            2: return CFG_W'(1024);
            default: return CFG_W'($urandom_range(3, 12));
        endcase
    endfunction

    // widths stay within the columns that the gap-free frame has filled
    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return CFG_W'($urandom_range(0, 2));
            1: return CFG_W'(FILL_W);
            2: return CFG_W'($urandom_range(13, FILL_W));
            default: return CFG_W'($urandom_range(3, 12));
        endcase
    endfunction

    task automatic write_size(input logic sel, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_size(sel, value);
        @(posedge i_clk);
    endtask

    task automatic send_pixel(input t_mag mag, input t_grad gx, input t_grad gy);
        while (gaps_on && $urandom_range(99) < 29) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_magnitude <= mag;
        i_grad_x    <= gx;
        i_grad_y    <= gy;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random(input t_mag mag);
        t_grad gx, gy;
        gx = rand_grad();
        case ($urandom_range(0, 5))
            0: gy = gx;
            1: gy = -gx;
            default: gy = rand_grad();
        endcase
        send_pixel(mag, gx, gy);
    endtask

    // hold off until no request is outstanding and the pipeline has run dry
    task automatic settle();
        int unsigned quiet;
        quiet = 0;
        i_in_valid <= 1'b0;
        while (quiet < 16) begin
            @(posedge i_clk);
            quiet = (sb.pending_count() == 0) ? quiet + 1 : 0;
        end
    endtask

    initial begin
        int unsigned n_random, len, k;
        bit flat;
        t_mag flat_mag, mag;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // three columns, seven rows: one interior centre on each of rows 1 to 5, covering every branch
        write_size(REG_IMAGE_WIDTH, 11'd2);
        write_size(REG_IMAGE_HEIGHT, 11'd7);
        for (k = 0; k < 21; k++) begin
            if (k % 3 == 1) begin
                send_pixel(16'hFFFF, DIR_GX[k/3], DIR_GY[k/3]);
            end else begin
                mag = (k % 3 == 0) ? 16'h0000 : rand_mag();
                send_random(mag);
            end
        end
        settle();

        // gap-free frame fills every line entry that later widths reach
        gaps_on = 1'b0;
        write_size(REG_IMAGE_WIDTH, CFG_W'(FILL_W));
        write_size(REG_IMAGE_HEIGHT, 11'd0);
        repeat (3 * FILL_W) send_random(rand_mag());
        settle();

        gaps_on = 1'b1;
        write_size(REG_IMAGE_WIDTH, 11'd3);
        write_size(REG_IMAGE_HEIGHT, 11'd1024);
        repeat (120) send_random(rand_mag());
        settle();

        // size changes land mid-frame from here on
        n_random = 0;
        while (n_random < 920) begin
            case ($urandom_range(0, 3))
                0: write_size(REG_IMAGE_WIDTH, pick_width());
                1: write_size(REG_IMAGE_HEIGHT, pick_size());
                default: begin
                    write_size(REG_IMAGE_WIDTH, pick_width());
                    write_size(REG_IMAGE_HEIGHT, pick_size());
                end
            endcase
            gaps_on  = ($urandom_range(0, 4) != 0);
            flat     = ($urandom_range(0, 2) == 0);
            flat_mag = rand_mag();
            len      = $urandom_range(4, 90);
            repeat (len) begin
                mag = (flat && $urandom_range(0, 7) != 0) ? flat_mag : rand_mag();
                send_random(mag);
            end
            n_random += len;
            settle();
        end

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
